/* rtl/lpff_pkg.sv */
// ----------------------------------------------------------------------------
// lpff_pkg
// Shared constants, result kinds and pointer-unit types for the
// length-prefixed frame FIFO.
// ----------------------------------------------------------------------------
package lpff_pkg;

  localparam int STORE_DEPTH = 128;
  localparam int PTR_W       = $clog2(STORE_DEPTH);
  // space values run from 0 to STORE_DEPTH inclusive
  localparam int SPACE_W     = PTR_W + 1;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 5;
  localparam int CNT_W  = 5;
  localparam int HDR_W  = 4;
  localparam int KIND_W = 3;

  localparam logic [BYTE_W-1:0] NIBBLE_MASK = 8'h0F;
  localparam logic [LEN_W-1:0]  LEN_BIAS    = 5'd3;
  localparam logic [CNT_W-1:0]  CNT_MAX     = 5'd31;

  localparam logic [KIND_W-1:0] KIND_WR_OK    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WR_REJ   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BYTE     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FLUSH    = 3'd4;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [1:0] {
    ALU_SUB_WRAP = 2'b01,
    ALU_INC_WRAP = 2'b10
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [PTR_W-1:0] a;
    logic [PTR_W-1:0] b;
  } alu_req_t;

endpackage

/* rtl/lpff_ram.sv */
// ----------------------------------------------------------------------------
// lpff_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/lpff_alu.sv */
// ----------------------------------------------------------------------------
// lpff_alu
// Shared pointer unit: circular distance between two pointers, or a
// wrapping increment of one pointer.
// ----------------------------------------------------------------------------
module lpff_alu (
  input  lpff_pkg::alu_req_t         req,
  output logic [lpff_pkg::PTR_W-1:0] y
);

  logic [lpff_pkg::SPACE_W-1:0] a_ext;
  logic [lpff_pkg::SPACE_W-1:0] b_ext;
  logic [lpff_pkg::SPACE_W-1:0] sum;

  assign a_ext = {1'b0, req.a};
  assign b_ext = {1'b0, req.b};

  always_comb begin
    unique case (req.op)
      lpff_pkg::ALU_INC_WRAP: begin
        if (a_ext == lpff_pkg::SPACE_W'(lpff_pkg::STORE_DEPTH - 1)) begin
          sum = '0;
        end else begin
          sum = a_ext + 1'b1;
        end
      end
      default: begin
        // a >= b: plain difference, else add the depth back
        if (a_ext >= b_ext) begin
          sum = a_ext - b_ext;
        end else begin
          sum = a_ext + lpff_pkg::SPACE_W'(lpff_pkg::STORE_DEPTH) - b_ext;
        end
      end
    endcase
  end

  assign y = sum[lpff_pkg::PTR_W-1:0];

endmodule

/* rtl/length_prefixed_frame_fifo_unit.sv */
// ----------------------------------------------------------------------------
// length_prefixed_frame_fifo_unit
// Circular byte store of whole frames with a length nibble in the header byte.
// Write: each beat has a space check and store (S_WCHK), a position increment
//   if it fits (S_WINC) and a count (S_WFIN); a frame's last beat then holds
//   its result in the output register. A read fetches the header, then each
//   frame byte, all through the single shared pointer unit and one RAM read port.
// One input beat at a time; in_stall stays high until all its results leave.
// Reset (synchronous): head, tail, staging state and flags clear; the byte
//   store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module length_prefixed_frame_fifo_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_op,
  input  logic [lpff_pkg::BYTE_W-1:0]    in_data_byte,
  input  logic                           in_frame_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lpff_pkg::KIND_W-1:0]    out_kind,
  output logic [lpff_pkg::BYTE_W-1:0]    out_out_byte,
  output logic [lpff_pkg::LEN_W-1:0]     out_frame_length,
  output logic                           out_last
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_WCHK  = 8'b0000_0010,
    S_WINC  = 8'b0000_0100,
    S_WFIN  = 8'b0000_1000,
    S_RWAIT = 8'b0001_0000,
    S_RHDR  = 8'b0010_0000,
    S_RBYTE = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [lpff_pkg::PTR_W-1:0]  head_r, tail_r, stage_pos_r, rd_ptr_r;
  logic                        empty_r, stage_bad_r;
  logic [lpff_pkg::CNT_W-1:0]  stage_count_r;
  logic [lpff_pkg::HDR_W-1:0]  stage_header_r;
  logic [lpff_pkg::BYTE_W-1:0] wbyte_r;
  logic                        wend_r;
  logic [lpff_pkg::LEN_W-1:0]  len_r, cnt_r;
  logic [lpff_pkg::KIND_W-1:0] kind_r;
  logic [lpff_pkg::BYTE_W-1:0] obyte_r;
  logic [lpff_pkg::LEN_W-1:0]  olen_r;
  logic                        olast_r;

  lpff_pkg::alu_req_t          alu_req;
  logic [lpff_pkg::PTR_W-1:0]  alu_y;
  logic [lpff_pkg::BYTE_W-1:0] ram_rdata;
  logic                        ram_we;

  logic [lpff_pkg::SPACE_W-1:0] free_w, used_w;
  logic                         fit_w;
  logic [lpff_pkg::CNT_W-1:0]   count_sat_w;
  logic                         frame_ok_w;
  logic [lpff_pkg::LEN_W-1:0]   rd_len_w;
  logic                         rd_last_w;
  logic                         in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // pointer unit operand select
  always_comb begin
    alu_req.op = lpff_pkg::ALU_SUB_WRAP;
    alu_req.a  = tail_r;
    alu_req.b  = head_r;
    unique case (state_r)
      S_WINC: begin
        alu_req.op = lpff_pkg::ALU_INC_WRAP;
        alu_req.a  = stage_pos_r;
      end
      S_RHDR: begin
        alu_req.a = head_r;
        alu_req.b = tail_r;
      end
      S_RBYTE: begin
        alu_req.op = lpff_pkg::ALU_INC_WRAP;
        alu_req.a  = rd_ptr_r;
      end
      default: begin
      end
    endcase
  end

  lpff_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  assign ram_we = (state_r == S_WCHK) && fit_w;

  lpff_ram #(
    .WIDTH (lpff_pkg::BYTE_W),
    .DEPTH (lpff_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (stage_pos_r),
    .wdata (wbyte_r),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // tail == head with data present means a full store
  assign free_w = empty_r ? lpff_pkg::SPACE_W'(lpff_pkg::STORE_DEPTH) : {1'b0, alu_y};
  assign used_w = empty_r ? '0 :
                  (head_r == tail_r) ? lpff_pkg::SPACE_W'(lpff_pkg::STORE_DEPTH) :
                  {1'b0, alu_y};
  assign fit_w  = lpff_pkg::SPACE_W'(stage_count_r) < free_w;

  assign count_sat_w = (stage_count_r == lpff_pkg::CNT_MAX) ? lpff_pkg::CNT_MAX :
                       stage_count_r + 1'b1;
  assign frame_ok_w  = !stage_bad_r &&
                       (count_sat_w == (lpff_pkg::LEN_W'(stage_header_r) + lpff_pkg::LEN_BIAS));

  assign rd_len_w  = lpff_pkg::LEN_W'(ram_rdata & lpff_pkg::NIBBLE_MASK) + lpff_pkg::LEN_BIAS;
  assign rd_last_w = (cnt_r + 1'b1) == len_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_op == lpff_pkg::OP_WRITE) begin
            state_nxt = S_WCHK;
          end else if (empty_r) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_RWAIT;
          end
        end
      end
      S_WCHK:  state_nxt = fit_w ? S_WINC : S_WFIN;
      S_WINC:  state_nxt = S_WFIN;
      S_WFIN:  state_nxt = wend_r ? S_OUT : S_IDLE;
      S_RWAIT: state_nxt = S_RHDR;
      S_RHDR:  state_nxt = (used_w < lpff_pkg::SPACE_W'(rd_len_w)) ? S_OUT : S_RBYTE;
      S_RBYTE: state_nxt = S_OUT;
      S_OUT: begin
        if (out_acc) begin
          state_nxt = olast_r ? S_IDLE : S_RBYTE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      head_r         <= '0;
      tail_r         <= '0;
      empty_r        <= 1'b1;
      stage_pos_r    <= '0;
      stage_count_r  <= '0;
      stage_header_r <= '0;
      stage_bad_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          // first beat of a frame opens a new staging run at the head
          if (in_acc && in_op == lpff_pkg::OP_WRITE && stage_count_r == '0) begin
            stage_header_r <= lpff_pkg::HDR_W'(in_data_byte & lpff_pkg::NIBBLE_MASK);
            stage_pos_r    <= head_r;
            stage_bad_r    <= 1'b0;
          end
        end
        S_WCHK: begin
          if (!fit_w) begin
            stage_bad_r <= 1'b1;
          end
        end
        S_WINC: begin
          stage_pos_r <= alu_y;
        end
        S_WFIN: begin
          if (wend_r) begin
            if (frame_ok_w) begin
              head_r  <= stage_pos_r;
              empty_r <= 1'b0;
            end
            stage_count_r <= '0;
            stage_bad_r   <= 1'b0;
          end else begin
            stage_count_r <= count_sat_w;
          end
        end
        S_RHDR: begin
          if (used_w < lpff_pkg::SPACE_W'(rd_len_w)) begin
            tail_r  <= head_r;
            empty_r <= 1'b1;
          end
        end
        S_RBYTE: begin
          if (rd_last_w) begin
            tail_r <= alu_y;
            if (alu_y == head_r) begin
              empty_r <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload and output registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          wbyte_r  <= in_data_byte;
          wend_r   <= in_frame_end;
          rd_ptr_r <= tail_r;
          cnt_r    <= '0;
          kind_r   <= lpff_pkg::KIND_EMPTY;
          obyte_r  <= '0;
          olen_r   <= '0;
          olast_r  <= 1'b1;
        end
      end
      S_WFIN: begin
        kind_r  <= frame_ok_w ? lpff_pkg::KIND_WR_OK : lpff_pkg::KIND_WR_REJ;
        obyte_r <= '0;
        olen_r  <= '0;
        olast_r <= 1'b1;
      end
      S_RHDR: begin
        len_r   <= rd_len_w;
        kind_r  <= lpff_pkg::KIND_FLUSH;
        obyte_r <= '0;
        olen_r  <= rd_len_w;
        olast_r <= 1'b1;
      end
      S_RBYTE: begin
        kind_r   <= lpff_pkg::KIND_BYTE;
        obyte_r  <= ram_rdata;
        olen_r   <= len_r;
        olast_r  <= rd_last_w;
        rd_ptr_r <= alu_y;
        cnt_r    <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = (state_r == S_OUT);
  assign out_kind         = kind_r;
  assign out_out_byte     = obyte_r;
  assign out_frame_length = olen_r;
  assign out_last         = olast_r;

endmodule

/* rtl/lpff_checker.sv */
// ----------------------------------------------------------------------------
// lpff_checker
// Port-level checks for the frame FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module lpff_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [lpff_pkg::KIND_W-1:0] out_kind,
  input logic [lpff_pkg::BYTE_W-1:0] out_out_byte,
  input logic [lpff_pkg::LEN_W-1:0]  out_frame_length,
  input logic                        out_last
);

  // one beat at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // no new beat while a result is pending
  a_stall_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input ready while result pending");

  // only frame bytes carry a data byte; write and empty results carry no length
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind != lpff_pkg::KIND_BYTE) |-> (out_out_byte == '0))
    else $error("data byte on non-byte result");

  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == lpff_pkg::KIND_WR_OK || out_kind == lpff_pkg::KIND_WR_REJ ||
                   out_kind == lpff_pkg::KIND_EMPTY)) |-> (out_frame_length == '0 && out_last))
    else $error("bad length or last on single result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_kind) && $stable(out_out_byte)))
    else $error("stalled result changed");

endmodule

bind length_prefixed_frame_fifo_unit lpff_checker u_lpff_checker (.*);
